### hw/rtl/cpu6502_execute_unit_defines.svh
// ----------------------------------------------------------------------------
// cpu6502_execute_unit_defines.svh
// assertion macros used by the execute unit checker
// ----------------------------------------------------------------------------
`ifndef CPU6502_EXECUTE_UNIT_DEFINES_SVH
`define CPU6502_EXECUTE_UNIT_DEFINES_SVH

// clocked assertion, quiet while reset is asserted
`define C65X_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked assertion that also holds through reset
`define C65X_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hw/rtl/c65x_pkg.sv
// ----------------------------------------------------------------------------
// c65x_pkg
// types, opcodes and constants of the 6502 execute unit
// ----------------------------------------------------------------------------
package c65x_pkg;

  typedef enum logic [5:0] {
    OP_ORA = 6'd0,  OP_AND = 6'd1,  OP_EOR = 6'd2,  OP_ADC = 6'd3,
    OP_STA = 6'd4,  OP_LDA = 6'd5,  OP_CMP = 6'd6,  OP_SBC = 6'd7,
    OP_BIT = 6'd8,  OP_JMP = 6'd9,  OP_STY = 6'd10, OP_LDY = 6'd11,
    OP_CPY = 6'd12, OP_CPX = 6'd13, OP_ASL = 6'd14, OP_ROL = 6'd15,
    OP_LSR = 6'd16, OP_ROR = 6'd17, OP_STX = 6'd18, OP_LDX = 6'd19,
    OP_DEC = 6'd20, OP_INC = 6'd21, OP_DEX = 6'd22, OP_DEY = 6'd23,
    OP_INX = 6'd24, OP_INY = 6'd25, OP_BRA = 6'd26, OP_CLC = 6'd27,
    OP_SEC = 6'd28, OP_CLI = 6'd29, OP_SEI = 6'd30, OP_CLV = 6'd31,
    OP_CLD = 6'd32, OP_SED = 6'd33, OP_TAX = 6'd34, OP_TXA = 6'd35,
    OP_TAY = 6'd36, OP_TYA = 6'd37, OP_TSX = 6'd38, OP_TXS = 6'd39,
    OP_NOP = 6'd40
  } op_e;

  // branch flag select, bits 2..1 of the condition
  typedef enum logic [1:0] {
    BR_N = 2'd0,
    BR_V = 2'd1,
    BR_C = 2'd2,
    BR_Z = 2'd3
  } br_sel_e;

  // status bit positions
  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagI = 2;
  localparam int unsigned FlagD = 3;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagN = 7;

  localparam logic [7:0] ResetS = 8'hFD;
  localparam logic [7:0] ResetP = 8'h24;

  typedef struct packed {
    logic [5:0]  opcode;
    logic [7:0]  operand;
    logic [15:0] target_addr;
    logic        on_accumulator;
    logic [2:0]  branch_cond;
    logic [15:0] next_pc;
  } item_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] s;
    logic [7:0] p;
  } regs_t;

  typedef struct packed {
    logic        mem_write;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    logic [15:0] new_pc;
    logic [7:0]  acc_out;
    logic [7:0]  status_out;
  } res_t;

  // status with N and Z taken from a result byte
  function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] r;
    r = p;
    r[FlagN] = v[7];
    r[FlagZ] = (v == 8'h00);
    return r;
  endfunction

endpackage

### hw/rtl/c65x_in_stage.sv
// ----------------------------------------------------------------------------
// c65x_in_stage
// input register holding one decoded request
// ----------------------------------------------------------------------------
module c65x_in_stage
  import c65x_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  input  logic  advance_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### hw/rtl/c65x_alu.sv
// ----------------------------------------------------------------------------
// c65x_alu
// single-pass operation logic: next register file and result of one request
// ----------------------------------------------------------------------------
module c65x_alu
  import c65x_pkg::*;
(
  input  item_t item_i,
  input  regs_t regs_i,
  output regs_t regs_o,
  output res_t  res_o
);

  logic [7:0] m;
  logic       cin;
  logic [7:0] m_add;
  logic [8:0] sum;
  logic       ovf;
  logic [7:0] cmp_reg;
  logic [8:0] diff;
  logic [7:0] src;
  logic [7:0] shl;
  logic [7:0] shr;
  logic       is_left;
  logic [7:0] sh_res;
  logic       sh_cout;
  logic       flag;
  logic       wr;
  logic [7:0] wdata;
  logic [7:0] dec_m;
  logic [7:0] inc_m;
  logic [15:0] pc;
  op_e        op;

  assign op  = op_e'(item_i.opcode);
  assign m   = item_i.operand;
  assign cin = regs_i.p[FlagC];

  // adder shared by adc and sbc, sbc adds the inverted operand
  assign m_add = (op == OP_SBC) ? ~m : m;
  assign sum   = {1'b0, regs_i.a} + {1'b0, m_add} + {8'h00, cin};
  assign ovf   = ~(regs_i.a[7] ^ m_add[7]) & (regs_i.a[7] ^ sum[7]);

  always_comb begin
    case (op)
      OP_CPX:  cmp_reg = regs_i.x;
      OP_CPY:  cmp_reg = regs_i.y;
      default: cmp_reg = regs_i.a;
    endcase
  end
  assign diff = {1'b0, cmp_reg} - {1'b0, m};

  assign src     = item_i.on_accumulator ? regs_i.a : m;
  assign shl     = {src[6:0], (op == OP_ROL) ? cin : 1'b0};
  assign shr     = {(op == OP_ROR) ? cin : 1'b0, src[7:1]};
  assign is_left = (op == OP_ASL) || (op == OP_ROL);
  assign sh_res  = is_left ? shl : shr;
  assign sh_cout = is_left ? src[7] : src[0];

  assign dec_m = m - 8'd1;
  assign inc_m = m + 8'd1;

  always_comb begin
    case (br_sel_e'(item_i.branch_cond[2:1]))
      BR_N:    flag = regs_i.p[FlagN];
      BR_V:    flag = regs_i.p[FlagV];
      BR_C:    flag = regs_i.p[FlagC];
      default: flag = regs_i.p[FlagZ];
    endcase
  end

  always_comb begin
    regs_o = regs_i;
    wr     = 1'b0;
    wdata  = 8'h00;
    pc     = item_i.next_pc;
    case (op)
      OP_ORA: begin
        regs_o.a = regs_i.a | m;
        regs_o.p = with_nz(regs_i.p, regs_o.a);
      end
      OP_AND: begin
        regs_o.a = regs_i.a & m;
        regs_o.p = with_nz(regs_i.p, regs_o.a);
      end
      OP_EOR: begin
        regs_o.a = regs_i.a ^ m;
        regs_o.p = with_nz(regs_i.p, regs_o.a);
      end
      OP_ADC, OP_SBC: begin
        regs_o.a        = sum[7:0];
        regs_o.p        = with_nz(regs_i.p, sum[7:0]);
        regs_o.p[FlagC] = sum[8];
        regs_o.p[FlagV] = ovf;
      end
      OP_STA: begin
        wr    = 1'b1;
        wdata = regs_i.a;
      end
      OP_LDA: begin
        regs_o.a = m;
        regs_o.p = with_nz(regs_i.p, m);
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        regs_o.p        = with_nz(regs_i.p, diff[7:0]);
        regs_o.p[FlagC] = !diff[8];
      end
      OP_BIT: begin
        regs_o.p[FlagZ] = ((regs_i.a & m) == 8'h00);
        regs_o.p[FlagV] = m[6];
        regs_o.p[FlagN] = m[7];
      end
      OP_JMP: pc = item_i.target_addr;
      OP_STY: begin
        wr    = 1'b1;
        wdata = regs_i.y;
      end
      OP_LDY: begin
        regs_o.y = m;
        regs_o.p = with_nz(regs_i.p, m);
      end
      OP_ASL, OP_ROL, OP_LSR, OP_ROR: begin
        regs_o.p        = with_nz(regs_i.p, sh_res);
        regs_o.p[FlagC] = sh_cout;
        if (item_i.on_accumulator) begin
          regs_o.a = sh_res;
        end else begin
          wr    = 1'b1;
          wdata = sh_res;
        end
      end
      OP_STX: begin
        wr    = 1'b1;
        wdata = regs_i.x;
      end
      OP_LDX: begin
        regs_o.x = m;
        regs_o.p = with_nz(regs_i.p, m);
      end
      OP_DEC: begin
        wr       = 1'b1;
        wdata    = dec_m;
        regs_o.p = with_nz(regs_i.p, dec_m);
      end
      OP_INC: begin
        wr       = 1'b1;
        wdata    = inc_m;
        regs_o.p = with_nz(regs_i.p, inc_m);
      end
      OP_DEX: begin
        regs_o.x = regs_i.x - 8'd1;
        regs_o.p = with_nz(regs_i.p, regs_o.x);
      end
      OP_DEY: begin
        regs_o.y = regs_i.y - 8'd1;
        regs_o.p = with_nz(regs_i.p, regs_o.y);
      end
      OP_INX: begin
        regs_o.x = regs_i.x + 8'd1;
        regs_o.p = with_nz(regs_i.p, regs_o.x);
      end
      OP_INY: begin
        regs_o.y = regs_i.y + 8'd1;
        regs_o.p = with_nz(regs_i.p, regs_o.y);
      end
      OP_BRA: begin
        // taken when the selected flag matches the wanted value
        if (flag == item_i.branch_cond[0]) begin
          pc = item_i.next_pc + {{8{m[7]}}, m};
        end
      end
      OP_CLC: regs_o.p[FlagC] = 1'b0;
      OP_SEC: regs_o.p[FlagC] = 1'b1;
      OP_CLI: regs_o.p[FlagI] = 1'b0;
      OP_SEI: regs_o.p[FlagI] = 1'b1;
      OP_CLV: regs_o.p[FlagV] = 1'b0;
      OP_CLD: regs_o.p[FlagD] = 1'b0;
      OP_SED: regs_o.p[FlagD] = 1'b1;
      OP_TAX: begin
        regs_o.x = regs_i.a;
        regs_o.p = with_nz(regs_i.p, regs_i.a);
      end
      OP_TXA: begin
        regs_o.a = regs_i.x;
        regs_o.p = with_nz(regs_i.p, regs_i.x);
      end
      OP_TAY: begin
        regs_o.y = regs_i.a;
        regs_o.p = with_nz(regs_i.p, regs_i.a);
      end
      OP_TYA: begin
        regs_o.a = regs_i.y;
        regs_o.p = with_nz(regs_i.p, regs_i.y);
      end
      OP_TSX: begin
        regs_o.x = regs_i.s;
        regs_o.p = with_nz(regs_i.p, regs_i.s);
      end
      OP_TXS: regs_o.s = regs_i.x;
      default: begin
      end
    endcase
  end

  always_comb begin
    res_o.mem_write  = wr;
    res_o.write_addr = wr ? item_i.target_addr : 16'h0000;
    res_o.write_data = wdata;
    res_o.new_pc     = pc;
    res_o.acc_out    = regs_o.a;
    res_o.status_out = regs_o.p;
  end

endmodule

### hw/rtl/c65x_out_stage.sv
// ----------------------------------------------------------------------------
// c65x_out_stage
// architectural registers and the result register
// ----------------------------------------------------------------------------
module c65x_out_stage
  import c65x_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  regs_t regs_i,
  input  res_t  res_i,
  output regs_t regs_o,
  output logic  space_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  res_o
);

  regs_t regs_q;
  logic  valid_q, valid_d;
  res_t  res_q;

  // result slot frees up in the same cycle it is taken
  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (space_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      regs_q  <= '{a: 8'h00, x: 8'h00, y: 8'h00, s: ResetS, p: ResetP};
    end else begin
      valid_q <= valid_d;
      if (load_i) begin
        regs_q <= regs_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign regs_o      = regs_q;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

### hw/rtl/cpu6502_execute_unit.sv
// ----------------------------------------------------------------------------
// cpu6502_execute_unit
// execute stage for decoded 6502 operations, binary arithmetic only
// ----------------------------------------------------------------------------
// Each request is held in the input register and then lands in the
// result register together with the update of A, X, Y, S and P, and one
// request can retire per clock while results are taken.
// The only limit on rate is the result register: when it is full and not
// taken, the input side stalls after one more request is buffered.
module cpu6502_execute_unit
  import c65x_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [5:0]  opcode_i,
  input  logic [7:0]  operand_i,
  input  logic [15:0] target_addr_i,
  input  logic        on_accumulator_i,
  input  logic [2:0]  branch_cond_i,
  input  logic [15:0] next_pc_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        mem_write_o,
  output logic [15:0] write_addr_o,
  output logic [7:0]  write_data_o,
  output logic [15:0] new_pc_o,
  output logic [7:0]  acc_out_o,
  output logic [7:0]  status_out_o
);

  item_t item_in;
  item_t item_q;
  logic  item_valid;
  logic  space;
  logic  advance;
  regs_t regs_cur;
  regs_t regs_nxt;
  res_t  res_nxt;
  res_t  res_q;

  assign item_in = '{opcode: opcode_i, operand: operand_i, target_addr: target_addr_i,
                     on_accumulator: on_accumulator_i, branch_cond: branch_cond_i,
                     next_pc: next_pc_i};

  assign advance = item_valid && space;

  c65x_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item_in),
    .advance_i  (advance),
    .valid_o    (item_valid),
    .item_o     (item_q)
  );

  c65x_alu u_alu (
    .item_i (item_q),
    .regs_i (regs_cur),
    .regs_o (regs_nxt),
    .res_o  (res_nxt)
  );

  c65x_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .regs_i      (regs_nxt),
    .res_i       (res_nxt),
    .regs_o      (regs_cur),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_q)
  );

  assign mem_write_o  = res_q.mem_write;
  assign write_addr_o = res_q.write_addr;
  assign write_data_o = res_q.write_data;
  assign new_pc_o     = res_q.new_pc;
  assign acc_out_o    = res_q.acc_out;
  assign status_out_o = res_q.status_out;

endmodule

### hw/rtl/c65x_checker.sv
// ----------------------------------------------------------------------------
// c65x_checker
// port-level checks on the execute unit, bound to the top level
// ----------------------------------------------------------------------------
`include "cpu6502_execute_unit_defines.svh"

module c65x_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        mem_write_o,
  input logic [15:0] write_addr_o,
  input logic [7:0]  write_data_o,
  input logic [15:0] new_pc_o,
  input logic [7:0]  acc_out_o,
  input logic [7:0]  status_out_o
);

  // a pending result holds until taken
  `C65X_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(acc_out_o) && $stable(status_out_o) && $stable(new_pc_o), "result changed while stalled")

  // no write request means zero address and data
  `C65X_ASSERT(a_no_write_zero, out_valid_o && !mem_write_o |-> write_addr_o == 16'h0000 && write_data_o == 8'h00, "stray write fields")

  // the two unused status bits keep their reset values
  `C65X_ASSERT(a_fixed_bits, out_valid_o |-> status_out_o[5] && !status_out_o[4], "status bits 5 or 4 changed")

  // an empty result slot never blocks the input
  `C65X_ASSERT_ALWAYS(a_ready_when_empty, rst_ni && !out_valid_o |-> in_ready_o, "input stalled with empty output")

endmodule

bind cpu6502_execute_unit c65x_checker u_checker (.*);

### bench/cpu6502_execute_checker.sv
// ----------------------------------------------------------------------------
// cpu6502_execute_checker
// predicts and checks every result of the 6502 execute unit
// ----------------------------------------------------------------------------
// Watches both channels. On each accepted request it updates its own copy of
// A, X, Y, S and P and queues the result that the request must produce. Each
// accepted result is checked field by field against the oldest queued one.
`timescale 1ns / 100ps

module cpu6502_execute_checker
  import c65x_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [5:0]  opcode_i,
  input  logic [7:0]  operand_i,
  input  logic [15:0] target_addr_i,
  input  logic        on_accumulator_i,
  input  logic [2:0]  branch_cond_i,
  input  logic [15:0] next_pc_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        mem_write_i,
  input  logic [15:0] write_addr_i,
  input  logic [7:0]  write_data_i,
  input  logic [15:0] new_pc_i,
  input  logic [7:0]  acc_out_i,
  input  logic [7:0]  status_out_i,
  output int          errors_o,
  output int          pending_o
);

  logic [7:0] acc_q;
  logic [7:0] x_q;
  logic [7:0] y_q;
  logic [7:0] sp_q;
  logic [7:0] flags_q;

  res_t pending_results[$];
  int   mismatches = 0;
  int   results_seen = 0;

  assign errors_o = mismatches;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("[%0t] result %0d: %s got %0h, want %0h", $realtime, results_seen, what,
             got, want);
  endtask

  task automatic check_field(input string what, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_mismatch(what, got, want);
    end
  endtask

  function automatic void update_nz(input logic [7:0] v);
    flags_q[FlagN] = v[7];
    flags_q[FlagZ] = (v == 8'h00);
  endfunction

  function automatic void add_carry(input logic [7:0] m);
    logic [8:0] sum;
    sum = {1'b0, acc_q} + {1'b0, m} + {8'h00, flags_q[FlagC]};
    flags_q[FlagC] = sum[8];
    // signed overflow: both inputs share a sign that the sum does not
    flags_q[FlagV] = ~(acc_q[7] ^ m[7]) & (acc_q[7] ^ sum[7]);
    acc_q = sum[7:0];
    update_nz(acc_q);
  endfunction

  function automatic void compare(input logic [7:0] r, input logic [7:0] m);
    logic [7:0] diff;
    diff = r - m;
    flags_q[FlagC] = (r >= m);
    update_nz(diff);
  endfunction

  function automatic res_t retire_op(input item_t req);
    res_t        r;
    logic        wr;
    logic [7:0]  wd;
    logic [7:0]  src;
    logic [7:0]  shifted;
    logic [15:0] pc;
    logic        cin;
    logic        flag;
    wr  = 1'b0;
    wd  = 8'h00;
    pc  = req.next_pc;
    cin = flags_q[FlagC];
    case (req.opcode)
      OP_ORA: begin acc_q = acc_q | req.operand; update_nz(acc_q); end
      OP_AND: begin acc_q = acc_q & req.operand; update_nz(acc_q); end
      OP_EOR: begin acc_q = acc_q ^ req.operand; update_nz(acc_q); end
      OP_ADC: add_carry(req.operand);
      OP_STA: begin wr = 1'b1; wd = acc_q; end
      OP_LDA: begin acc_q = req.operand; update_nz(acc_q); end
      OP_CMP: compare(acc_q, req.operand);
      OP_SBC: add_carry(~req.operand);
      OP_BIT: begin
        flags_q[FlagZ] = ((acc_q & req.operand) == 8'h00);
        flags_q[FlagV] = req.operand[6];
        flags_q[FlagN] = req.operand[7];
      end
      OP_JMP: pc = req.target_addr;
      OP_STY: begin wr = 1'b1; wd = y_q; end
      OP_LDY: begin y_q = req.operand; update_nz(y_q); end
      OP_CPY: compare(y_q, req.operand);
      OP_CPX: compare(x_q, req.operand);
      OP_ASL, OP_ROL, OP_LSR, OP_ROR: begin
        src = req.on_accumulator ? acc_q : req.operand;
        if (req.opcode == OP_ASL || req.opcode == OP_ROL) begin
          shifted = {src[6:0], (req.opcode == OP_ROL) & cin};
          flags_q[FlagC] = src[7];
        end else begin
          shifted = {(req.opcode == OP_ROR) & cin, src[7:1]};
          flags_q[FlagC] = src[0];
        end
        update_nz(shifted);
        if (req.on_accumulator) begin
          acc_q = shifted;
        end else begin
          wr = 1'b1;
          wd = shifted;
        end
      end
      OP_STX: begin wr = 1'b1; wd = x_q; end
      OP_LDX: begin x_q = req.operand; update_nz(x_q); end
      OP_DEC: begin wr = 1'b1; wd = req.operand - 8'd1; update_nz(wd); end
      OP_INC: begin wr = 1'b1; wd = req.operand + 8'd1; update_nz(wd); end
      OP_DEX: begin x_q = x_q - 8'd1; update_nz(x_q); end
      OP_DEY: begin y_q = y_q - 8'd1; update_nz(y_q); end
      OP_INX: begin x_q = x_q + 8'd1; update_nz(x_q); end
      OP_INY: begin y_q = y_q + 8'd1; update_nz(y_q); end
      OP_BRA: begin
        case (br_sel_e'(req.branch_cond[2:1]))
          BR_N:    flag = flags_q[FlagN];
          BR_V:    flag = flags_q[FlagV];
          BR_C:    flag = flags_q[FlagC];
          default: flag = flags_q[FlagZ];
        endcase
        if (flag == req.branch_cond[0]) begin
          pc = req.next_pc + {{8{req.operand[7]}}, req.operand};
        end
      end
      OP_CLC: flags_q[FlagC] = 1'b0;
      OP_SEC: flags_q[FlagC] = 1'b1;
      OP_CLI: flags_q[FlagI] = 1'b0;
      OP_SEI: flags_q[FlagI] = 1'b1;
      OP_CLV: flags_q[FlagV] = 1'b0;
      OP_CLD: flags_q[FlagD] = 1'b0;
      OP_SED: flags_q[FlagD] = 1'b1;
      OP_TAX: begin x_q = acc_q; update_nz(x_q); end
      OP_TXA: begin acc_q = x_q; update_nz(acc_q); end
      OP_TAY: begin y_q = acc_q; update_nz(y_q); end
      OP_TYA: begin acc_q = y_q; update_nz(acc_q); end
      OP_TSX: begin x_q = sp_q; update_nz(x_q); end
      OP_TXS: sp_q = x_q;
      // nop and every unused code leave the state alone
      default: ;
    endcase
    r.mem_write  = wr;
    r.write_addr = wr ? req.target_addr : 16'h0000;
    r.write_data = wr ? wd : 8'h00;
    r.new_pc     = pc;
    r.acc_out    = acc_q;
    r.status_out = flags_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t  got;
    res_t  want;
    item_t req;
    if (!rst_ni) begin
      acc_q   = 8'h00;
      x_q     = 8'h00;
      y_q     = 8'h00;
      sp_q    = ResetS;
      flags_q = ResetP;
      pending_results.delete();
      pending_o <= 0;
    end else begin
      // results first: a request accepted at this edge cannot leave yet
      if (out_valid_i && out_ready_i) begin
        got = '{mem_write: mem_write_i, write_addr: write_addr_i,
                write_data: write_data_i, new_pc: new_pc_i,
                acc_out: acc_out_i, status_out: status_out_i};
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request pending", got.new_pc, 0);
        end else begin
          want = pending_results.pop_front();
          check_field("mem_write", got.mem_write, want.mem_write);
          check_field("write_addr", got.write_addr, want.write_addr);
          check_field("write_data", got.write_data, want.write_data);
          check_field("new_pc", got.new_pc, want.new_pc);
          check_field("acc_out", got.acc_out, want.acc_out);
          check_field("status_out", got.status_out, want.status_out);
        end
        results_seen++;
      end
      if (in_valid_i && in_ready_i) begin
        req = '{opcode: opcode_i, operand: operand_i, target_addr: target_addr_i,
                on_accumulator: on_accumulator_i, branch_cond: branch_cond_i,
                next_pc: next_pc_i};
        pending_results.push_back(retire_op(req));
      end
      pending_o <= pending_results.size();
    end
  end

endmodule

### bench/cpu6502_execute_unit_test.sv
// ----------------------------------------------------------------------------
// cpu6502_execute_unit_test
// randomized regression of the 6502 execute unit
// ----------------------------------------------------------------------------
// Sends a directed sweep over every operation and the corner cases of flags,
// shifts, wrapping counters and branch targets, then about 1850 random
// requests with random idle time on both channels, a long result stall and
// full drains. The checker beside the unit predicts and compares each result.
`timescale 1ns / 100ps

module cpu6502_execute_unit_test;
  import c65x_pkg::*;

  localparam int CycleLimit  = 600000;
  localparam int RandomCount = 1850;
  localparam int HoldCycles  = 150;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [5:0]  opcode_i = '0;
  logic [7:0]  operand_i = '0;
  logic [15:0] target_addr_i = '0;
  logic        on_accumulator_i = 1'b0;
  logic [2:0]  branch_cond_i = '0;
  logic [15:0] next_pc_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        mem_write_o;
  logic [15:0] write_addr_o;
  logic [7:0]  write_data_o;
  logic [15:0] new_pc_o;
  logic [7:0]  acc_out_o;
  logic [7:0]  status_out_o;

  int errors;
  int pending;
  int sent_count = 0;
  int cycle_count = 0;
  bit steady = 1'b0;

  logic [7:0]  corner_bytes[4] = '{8'h00, 8'hFF, 8'h80, 8'h7F};
  logic [15:0] corner_pcs[4]   = '{16'h0000, 16'hFFFF, 16'h0005, 16'hFFF8};

  cpu6502_execute_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .operand_i        (operand_i),
    .target_addr_i    (target_addr_i),
    .on_accumulator_i (on_accumulator_i),
    .branch_cond_i    (branch_cond_i),
    .next_pc_i        (next_pc_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .mem_write_o      (mem_write_o),
    .write_addr_o     (write_addr_o),
    .write_data_o     (write_data_o),
    .new_pc_o         (new_pc_o),
    .acc_out_o        (acc_out_o),
    .status_out_o     (status_out_o)
  );

  cpu6502_execute_checker exec_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .opcode_i         (opcode_i),
    .operand_i        (operand_i),
    .target_addr_i    (target_addr_i),
    .on_accumulator_i (on_accumulator_i),
    .branch_cond_i    (branch_cond_i),
    .next_pc_i        (next_pc_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .mem_write_i      (mem_write_o),
    .write_addr_i     (write_addr_o),
    .write_data_i     (write_data_o),
    .new_pc_i         (new_pc_o),
    .acc_out_i        (acc_out_o),
    .status_out_i     (status_out_o),
    .errors_o         (errors),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic item_t random_request();
    item_t req;
    if ($urandom_range(0, 99) < 4) begin
      req.opcode = 6'($urandom_range(41, 63));
    end else begin
      req.opcode = 6'($urandom_range(0, 40));
    end
    if ($urandom_range(0, 3) == 0) begin
      req.operand = corner_bytes[$urandom_range(0, 3)];
    end else begin
      req.operand = 8'($urandom());
    end
    req.target_addr    = 16'($urandom());
    req.on_accumulator = 1'($urandom_range(0, 1));
    req.branch_cond    = 3'($urandom_range(0, 7));
    // pcs near both ends make branch targets wrap
    if ($urandom_range(0, 9) == 0) begin
      req.next_pc = corner_pcs[$urandom_range(0, 3)] + 16'($urandom_range(0, 15));
    end else begin
      req.next_pc = 16'($urandom());
    end
    return req;
  endfunction

  task automatic offer(input item_t req);
    int gap;
    opcode_i         <= req.opcode;
    operand_i        <= req.operand;
    target_addr_i    <= req.target_addr;
    on_accumulator_i <= req.on_accumulator;
    branch_cond_i    <= req.branch_cond;
    next_pc_i        <= req.next_pc;
    in_valid_i       <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending until every queued result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // result side: random stalls, ready stretches and one long hold-off
  initial begin
    bit held;
    int stall;
    held = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && sent_count >= 600) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if ($urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner cases of arithmetic, shifts, wrapping and branch targets
    offer('{OP_LDA, 8'h7F, 16'h0000, 1'b0, 3'd0, 16'h0200});
    offer('{OP_ADC, 8'h01, 16'h0000, 1'b0, 3'd0, 16'h0202});
    offer('{OP_ADC, 8'hFF, 16'h0000, 1'b0, 3'd0, 16'h0204});
    offer('{OP_SBC, 8'h80, 16'h0000, 1'b0, 3'd0, 16'h0206});
    offer('{OP_CMP, 8'hFF, 16'h0000, 1'b0, 3'd0, 16'h0208});
    offer('{OP_BIT, 8'h00, 16'h0000, 1'b0, 3'd0, 16'h020A});
    offer('{OP_ASL, 8'h00, 16'hFFFF, 1'b1, 3'd0, 16'h020C});
    offer('{OP_ROL, 8'h80, 16'hFFFF, 1'b0, 3'd0, 16'h020E});
    offer('{OP_ROR, 8'h01, 16'h0000, 1'b0, 3'd0, 16'h0210});
    offer('{OP_LDX, 8'hFF, 16'h0000, 1'b0, 3'd0, 16'h0212});
    offer('{OP_INX, 8'h00, 16'h0000, 1'b0, 3'd0, 16'h0214});
    offer('{OP_DEY, 8'h00, 16'h0000, 1'b0, 3'd0, 16'h0216});
    offer('{OP_INC, 8'hFF, 16'h8001, 1'b0, 3'd0, 16'h0218});
    offer('{OP_DEC, 8'h00, 16'h7FFE, 1'b0, 3'd0, 16'h021A});
    offer('{OP_BRA, 8'h80, 16'h0000, 1'b0, {BR_Z, 1'b1}, 16'h0010});
    offer('{OP_BRA, 8'h80, 16'h0000, 1'b0, {BR_Z, 1'b0}, 16'h0010});
    offer('{OP_BRA, 8'h7F, 16'h0000, 1'b0, {BR_C, 1'b1}, 16'hFFF0});
    offer('{OP_BRA, 8'h7F, 16'h0000, 1'b0, {BR_C, 1'b0}, 16'hFFF0});

    // one request of every operation and of the last unused code
    for (int op = 0; op < 64; op++) begin
      if (op <= 40 || op == 63) begin
        offer('{6'(op), corner_bytes[op % 4], op[0] ? 16'hFFFF : 16'h0000, op[1],
                3'(op), corner_pcs[(op / 4) % 4]});
      end
    end
    drain();

    for (int i = 0; i < RandomCount; i++) begin
      // stretches with no sender idling
      steady = (i % 300) < 40;
      offer(random_request());
      if (i == RandomCount / 2) begin
        drain();
      end
    end
    steady = 1'b0;
    drain();
    repeat (8) @(posedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/c65x_pkg.sv
hw/rtl/c65x_in_stage.sv
hw/rtl/c65x_alu.sv
hw/rtl/c65x_out_stage.sv
hw/rtl/cpu6502_execute_unit.sv
hw/rtl/c65x_checker.sv
bench/cpu6502_execute_checker.sv
bench/cpu6502_execute_unit_test.sv
